// ===== hdl/bqd_pkg.sv =====
`default_nettype none

package bqd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 16;
    localparam int NUM_COEFS = 5;

    // APB register map, one 32-bit word per coefficient
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_B0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_B1 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_B2 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_A1 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_A2 = 3'd4;

    // product and accumulator widths
    localparam int PROD_W = COEF_W + SAMPLE_W;
    localparam int SHIFT_Q14 = 14;
    localparam int SHIFT_Q15 = 15;
    localparam int SUM_W = PROD_W - SHIFT_Q14 + 3;

    localparam logic OP_FILTER = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    typedef struct packed {
        logic    opcode;
        sample_t sample_in;
    } bqd_in_t;

    typedef struct packed {
        sample_t sample_out;
        logic    overflow;
    } bqd_out_t;

    typedef struct packed {
        coef_t b0;
        coef_t b1;
        coef_t b2;
        coef_t a1;
        coef_t a2;
    } bqd_coefs_t;

endpackage

`default_nettype wire

// ===== hdl/bqd_cfg_regs.sv =====
`default_nettype none

module bqd_cfg_regs (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bqd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bqd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bqd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready,
    output bqd_pkg::bqd_coefs_t                   coefs
);
    import bqd_pkg::*;

    bqd_coefs_t             coefs_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;
    coef_t                  wr_val;
    coef_t                  rd_val;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign wr_val  = coef_t'(pwdata[COEF_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coefs_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_B0:  coefs_reg.b0 <= wr_val;
                REG_B1:  coefs_reg.b1 <= wr_val;
                REG_B2:  coefs_reg.b2 <= wr_val;
                REG_A1:  coefs_reg.a1 <= wr_val;
                REG_A2:  coefs_reg.a2 <= wr_val;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_B0:  rd_val = coefs_reg.b0;
            REG_B1:  rd_val = coefs_reg.b1;
            REG_B2:  rd_val = coefs_reg.b2;
            REG_A1:  rd_val = coefs_reg.a1;
            REG_A2:  rd_val = coefs_reg.a2;
            default: rd_val = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-COEF_W){1'b0}}, rd_val};
    assign coefs  = coefs_reg;

endmodule

`default_nettype wire

// ===== hdl/bqd_datapath.sv =====
`default_nettype none

module bqd_datapath (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 item_en,
    input  wire bqd_pkg::bqd_in_t     item_in,
    input  wire bqd_pkg::bqd_coefs_t  coefs,
    output bqd_pkg::bqd_out_t         result
);
    import bqd_pkg::*;

    sample_t x1_reg, x2_reg, y1_reg, y2_reg;
    sample_t x;
    sample_t y;

    logic signed [PROD_W-1:0] p_b0, p_b1, p_b2, p_a1, p_a2;
    logic signed [SUM_W-1:0]  t_b0, t_b1, t_b2, t_a1, t_a2;
    logic signed [SUM_W-1:0]  sum;
    logic [SUM_W-SAMPLE_W:0]  sum_hi;
    logic                     ovf;
    logic                     is_clear;

    assign x        = item_in.sample_in;
    assign is_clear = (item_in.opcode == OP_CLEAR);

    assign p_b0 = coefs.b0 * x;
    assign p_b1 = coefs.b1 * x1_reg;
    assign p_b2 = coefs.b2 * x2_reg;
    assign p_a1 = coefs.a1 * y1_reg;
    assign p_a2 = coefs.a2 * y2_reg;

    // arithmetic shift = take the upper bits, then sign extend
    assign t_b0 = SUM_W'(signed'(p_b0[PROD_W-1:SHIFT_Q15]));
    assign t_b1 = SUM_W'(signed'(p_b1[PROD_W-1:SHIFT_Q14]));
    assign t_b2 = SUM_W'(signed'(p_b2[PROD_W-1:SHIFT_Q15]));
    assign t_a1 = SUM_W'(signed'(p_a1[PROD_W-1:SHIFT_Q14]));
    assign t_a2 = SUM_W'(signed'(p_a2[PROD_W-1:SHIFT_Q15]));

    assign sum = t_b0 + t_b1 + t_b2 - t_a1 - t_a2;
    assign y   = sample_t'(sum[SAMPLE_W-1:0]);

    // wrapped when the bits above the sample are not all copies of its sign
    assign sum_hi = sum[SUM_W-1:SAMPLE_W-1];
    assign ovf    = !((&sum_hi) || !(|sum_hi));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (item_en) begin
            if (is_clear) begin
                x1_reg <= '0;
                x2_reg <= '0;
                y1_reg <= '0;
                y2_reg <= '0;
            end else begin
                x1_reg <= x;
                x2_reg <= x1_reg;
                y1_reg <= y;
                y2_reg <= y1_reg;
            end
        end
    end

    always_comb begin
        if (is_clear) begin
            result.sample_out = '0;
            result.overflow   = 1'b0;
        end else begin
            result.sample_out = y;
            result.overflow   = ovf;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/fixed_point_biquad_iir.sv =====
// Second-order direct form I IIR section on signed 16-bit samples.
// Input channel s_valid/s_ready/s_data: opcode 0 filters sample_in,
// opcode 1 clears the four history registers and yields a zero result.
// Result channel m_valid/m_ready/m_data: sample_out (wrapped to 16 bits)
// and overflow, one result per input transfer, in order.
// Coefficients b0, b1, b2, a1, a2 sit on the APB port at byte addresses
// 0x00..0x10 (low 16 bits, two's complement); write them only while idle.
// m_valid rises in the cycle after the input transfer.
// Throughput: one sample per cycle unless the receiver stalls. The five
// products and the sum are combinational from the input and the history,
// as each output feeds the next sample; the result lands in the output register.
// A stalled receiver holds m_data; s_ready stays high while the output
// register is empty or is being emptied in the same cycle, so the block
// takes a new sample in the cycle its previous result is taken.
// Reset (aresetn low, synchronous) clears the coefficients, the history
// and the output valid flag.
`default_nettype none

module fixed_point_biquad_iir (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire bqd_pkg::bqd_in_t                 s_data,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output bqd_pkg::bqd_out_t                     m_data,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [bqd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [bqd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [bqd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                  pready
);
    import bqd_pkg::*;

    bqd_coefs_t coefs;
    bqd_out_t   result;
    bqd_out_t   m_data_reg;
    logic       m_valid_reg;
    logic       s_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    bqd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coefs   (coefs)
    );

    bqd_datapath u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (s_xfer),
        .item_in (s_data),
        .coefs   (coefs),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== bench/tb_fixed_point_biquad_iir.sv =====
module tb_fixed_point_biquad_iir;
    timeunit 1ns;
    timeprecision 1ps;

    import bqd_pkg::*;

    localparam int ITEMS_PER_PHASE = 175;
    localparam int NUM_PHASES      = 8;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 4;
    localparam int CYCLE_LIMIT     = 200000;

    localparam sample_t S_MAX = 16'sh7fff;
    localparam sample_t S_MIN = 16'sh8000;
    localparam coef_t   C_MAX = 16'sh7fff;
    localparam coef_t   C_MIN = 16'sh8000;

    // notch near DC and a narrow bandpass, Q15/Q14
    localparam coef_t K_NOTCH_B0 = 16'sd32674;
    localparam coef_t K_POLE_A1  = -16'sd32657;
    localparam coef_t K_NOTCH_A2 = 16'sd32581;
    localparam coef_t K_BP_GAIN  = 16'sd47;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic     s_valid = 1'b0;
    logic     s_ready;
    bqd_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    bqd_out_t m_data;

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fixed_point_biquad_iir dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // filter state mirror
    coef_t   coef_q [NUM_COEFS];
    sample_t x_hist1 = '0;
    sample_t x_hist2 = '0;
    sample_t y_hist1 = '0;
    sample_t y_hist2 = '0;

    bqd_in_t  pending_samples [$];
    bqd_out_t expected_out [$];
    int n_queued = 0;
    int n_checked = 0;
    int mismatches = 0;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    logic in_taken = 1'b0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic bqd_out_t biquad_step(bqd_in_t item);
        longint acc;
        bqd_out_t res;
        res = '0;
        if (item.opcode == OP_CLEAR) begin
            x_hist1 = '0;
            x_hist2 = '0;
            y_hist1 = '0;
            y_hist2 = '0;
            return res;
        end
        // shifts bind looser than + in SV, hence the brackets
        acc = ((longint'(coef_q[REG_B0]) * longint'(item.sample_in)) >>> SHIFT_Q15)
            + ((longint'(coef_q[REG_B1]) * longint'(x_hist1)) >>> SHIFT_Q14)
            + ((longint'(coef_q[REG_B2]) * longint'(x_hist2)) >>> SHIFT_Q15)
            - ((longint'(coef_q[REG_A1]) * longint'(y_hist1)) >>> SHIFT_Q14)
            - ((longint'(coef_q[REG_A2]) * longint'(y_hist2)) >>> SHIFT_Q15);
        res.sample_out = acc[SAMPLE_W-1:0];
        res.overflow   = (longint'(res.sample_out) != acc);
        x_hist2 = x_hist1;
        x_hist1 = item.sample_in;
        y_hist2 = y_hist1;
        y_hist1 = res.sample_out;
        return res;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    // sender: new transfer offered only once the previous one has gone
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_data  <= pending_samples.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // receiver, with its own long hold-off counter
    always @(negedge aclk) begin
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        bqd_out_t want;
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_out.size() == 0) begin
                    report($sformatf("unexpected result: sample_out %0d overflow %0b",
                                     m_data.sample_out, m_data.overflow));
                end else begin
                    want = expected_out.pop_front();
                    n_checked++;
                    if (m_data.sample_out !== want.sample_out ||
                        m_data.overflow !== want.overflow)
                        report($sformatf({"result %0d: expected sample_out %0d overflow %0b,",
                                          " got sample_out %0d overflow %0b"},
                                         n_checked, want.sample_out, want.overflow,
                                         m_data.sample_out, m_data.overflow));
                end
            end
            if (s_valid && s_ready)
                expected_out.push_back(biquad_step(s_data));
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fixed_point_biquad_iir regression: fail");
            $finish;
        end
    end

    task automatic apb_write(logic [REG_IDX_W-1:0] idx, coef_t value);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-COEF_W){value[COEF_W-1]}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // indexes past the last coefficient are ignored by the block
        if (idx <= REG_A2)
            coef_q[idx] = value;
    endtask

    task automatic apb_check(logic [REG_IDX_W-1:0] idx);
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata[COEF_W-1:0] !== coef_q[idx])
            report($sformatf("register %0d readback: expected %0d, got %0d",
                             idx, coef_q[idx], $signed(prdata[COEF_W-1:0])));
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_coefs(coef_t b0, coef_t b1, coef_t b2, coef_t a1, coef_t a2);
        apb_write(REG_B0, b0);
        apb_write(REG_B1, b1);
        apb_write(REG_B2, b2);
        apb_write(REG_A1, a1);
        apb_write(REG_A2, a2);
        for (int r = REG_B0; r <= REG_A2; r++)
            apb_check(r[REG_IDX_W-1:0]);
    endtask

    task automatic queue_item(logic op, sample_t smp);
        bqd_in_t it;
        it.opcode    = op;
        it.sample_in = smp;
        pending_samples.push_back(it);
        n_queued++;
    endtask

    task automatic wait_drained();
        while (n_checked != n_queued)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    function automatic sample_t rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 60)
            return sample_t'($urandom);
        if (pick < 85)
            return sample_t'(int'($urandom_range(512)) - 256);
        case ($urandom_range(3))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            default: return -16'sd1;
        endcase
    endfunction

    initial begin
        coef_t c [NUM_COEFS];
        for (int i = 0; i < NUM_COEFS; i++)
            coef_q[i] = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset coefficients: everything filters to zero
        queue_item(OP_FILTER, S_MAX);
        queue_item(OP_CLEAR, S_MIN);
        wait_drained();

        // writes beyond the coefficient map; the block leaves the map untouched
        for (int r = REG_A2 + 1; r < (1 << REG_IDX_W); r++)
            apb_write(r[REG_IDX_W-1:0], coef_t'($urandom));

        // most negative coefficients: the sum overflows and the output wraps
        set_coefs(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN);
        queue_item(OP_FILTER, S_MAX);
        queue_item(OP_FILTER, S_MIN);
        queue_item(OP_FILTER, S_MIN);
        queue_item(OP_FILTER, 16'sd1);
        queue_item(OP_FILTER, -16'sd1);
        queue_item(OP_FILTER, '0);
        queue_item(OP_CLEAR, S_MAX);
        queue_item(OP_FILTER, S_MIN);
        queue_item(OP_FILTER, S_MAX);
        queue_item(OP_FILTER, 16'sh5555);
        queue_item(OP_FILTER, 16'shaaaa);
        wait_drained();

        set_coefs(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        queue_item(OP_FILTER, S_MIN);
        queue_item(OP_FILTER, S_MIN);
        queue_item(OP_FILTER, S_MAX);
        queue_item(OP_FILTER, S_MAX);
        queue_item(OP_CLEAR, S_MIN);
        queue_item(OP_FILTER, -16'sd1);
        queue_item(OP_FILTER, 16'sd1);
        queue_item(OP_FILTER, '0);
        wait_drained();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                1: set_coefs(K_NOTCH_B0, K_POLE_A1, K_NOTCH_B0, K_POLE_A1, K_NOTCH_A2);
                2: set_coefs(K_BP_GAIN, '0, -K_BP_GAIN, K_POLE_A1, K_NOTCH_B0);
                default: begin
                    if (p == 4) begin
                        set_coefs(C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
                    end else begin
                        for (int i = 0; i < NUM_COEFS; i++)
                            c[i] = coef_t'($urandom);
                        set_coefs(c[0], c[1], c[2], c[3], c[4]);
                    end
                end
            endcase
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
                default: begin send_idle_pct = 11; recv_stall_pct = 11; end
            endcase
            // long receiver hold-off with the sender still offering
            if (p == 4)
                hold_req++;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                queue_item(($urandom_range(99) < 4) ? OP_CLEAR : OP_FILTER, rand_sample());
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0 && expected_out.size() == 0) begin
            $display("fixed_point_biquad_iir regression: pass");
        end else begin
            $display("fixed_point_biquad_iir regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/bqd_pkg.sv
hdl/bqd_cfg_regs.sv
hdl/bqd_datapath.sv
hdl/fixed_point_biquad_iir.sv
bench/tb_fixed_point_biquad_iir.sv
